// ===== rtl/core/gpca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gpca_pkg;

  localparam int NUM_USERS = 8;
  localparam int IDX_W     = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int USER_W    = 3;
  localparam int PRIO_W    = 2;
  localparam int TYPE_W    = 3;
  localparam int ERR_W     = 2;
  localparam int GAP_W     = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [TYPE_W-1:0] REQ_JOIN    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_REQUEST = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_DONE    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_LEAVE   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_TICK    = 3'd4;

  localparam logic [PRIO_W-1:0] PRIO_INVALID = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PRIO    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_GAP = 1'b0;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [USER_W-1:0] user_id;
    logic [PRIO_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic              grant_valid;
    logic [USER_W-1:0] grant_user;
    logic              busy_res;
    logic [USER_W-1:0] busy_user;
    logic [ERR_W-1:0]  error;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/core/gapped_priority_channel_arbiter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel arbiter. A word is taken when start is high and busy is low. Its
// result appears on out_word for one cycle, flagged by out_strobe, in the cycle
// after the word's last processing cycle; the receiver cannot stall it. A word
// that starts no selection pass (join, leave, a rejected request, or a request,
// done or tick that starts none) is processed in the cycle it is taken, so its
// result is strobed the cycle after the word is taken. A word that runs a
// selection pass enters the scan state: the pass walks the users one per cycle
// through a single priority comparator and busy stays high meanwhile. The
// user writes frame_gap through the APB port at byte address 0 while the
// block is idle; the block itself does not enforce this.
module gapped_priority_channel_arbiter (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire gpca_pkg::in_word_t       in_word,
  output logic                          out_strobe,
  output gpca_pkg::out_word_t           out_word,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [gpca_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gpca_pkg::DATA_W-1:0] pwdata,
  output logic [gpca_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import gpca_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [GAP_W-1:0]      frame_gap_r;
  logic [NUM_USERS-1:0]  present_r, present_nxt;
  logic [NUM_USERS-1:0]  waiting_r, waiting_nxt;
  logic [PRIO_W-1:0]     prio_r [NUM_USERS];
  logic                  prio_we;
  logic [IDX_W-1:0]      prio_wa;
  logic [PRIO_W-1:0]     prio_wd;
  logic                  hold_v_r, hold_v_nxt;
  logic [IDX_W-1:0]      hold_ix_r, hold_ix_nxt;
  logic                  prev_v_r, prev_v_nxt;
  logic [IDX_W-1:0]      prev_ix_r, prev_ix_nxt;
  logic [GAP_W-1:0]      ticks_r, ticks_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  best_v_r, best_v_nxt;
  logic [IDX_W-1:0]      best_ix_r, best_ix_nxt;
  logic [PRIO_W-1:0]     best_prio_r, best_prio_nxt;
  logic                  prev_cand_r, prev_cand_nxt;
  logic [ERR_W-1:0]      err_r, err_nxt;
  logic                  strobe_r, strobe_nxt;
  out_word_t             word_r, word_nxt;

  logic                  accept;
  logic                  cfg_we;
  logic [IDX_W-1:0]      uix;
  logic                  known;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign uix    = IDX_W'(in_word.user_id);
  assign known  = (int'(in_word.user_id) < NUM_USERS);

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == REG_FRAME_GAP) begin
      prdata = DATA_W'(frame_gap_r);
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    logic              try_sel;
    logic              go_scan;
    logic              cand;
    logic              is_prev;
    logic [1:0]        cnt_now;
    logic              pc_now;
    logic              bv_now;
    logic [IDX_W-1:0]  bix_now;
    logic [PRIO_W-1:0] bp_now;
    logic              pick_v;
    logic [IDX_W-1:0]  pick_ix;
    logic [GAP_W-1:0]  ticks_inc;

    state_nxt     = state_r;
    present_nxt   = present_r;
    waiting_nxt   = waiting_r;
    hold_v_nxt    = hold_v_r;
    hold_ix_nxt   = hold_ix_r;
    prev_v_nxt    = prev_v_r;
    prev_ix_nxt   = prev_ix_r;
    ticks_nxt     = ticks_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    best_v_nxt    = best_v_r;
    best_ix_nxt   = best_ix_r;
    best_prio_nxt = best_prio_r;
    prev_cand_nxt = prev_cand_r;
    err_nxt       = err_r;
    strobe_nxt    = 1'b0;
    word_nxt      = word_r;
    prio_we       = 1'b0;
    prio_wa       = uix;
    prio_wd       = in_word.priority_req;
    try_sel       = 1'b0;
    go_scan       = 1'b0;
    cand          = 1'b0;
    is_prev       = 1'b0;
    cnt_now       = cnt_r;
    pc_now        = prev_cand_r;
    bv_now        = best_v_r;
    bix_now       = best_ix_r;
    bp_now        = best_prio_r;
    pick_v        = 1'b0;
    pick_ix       = '0;
    ticks_inc     = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          err_nxt = ERR_NONE;
          case (in_word.req_type)
            REQ_JOIN: begin
              if (in_word.priority_req == PRIO_INVALID) begin
                err_nxt = ERR_PRIO;
              end else if (known) begin
                present_nxt[uix] = 1'b1;
                waiting_nxt[uix] = 1'b0;
                prio_we          = 1'b1;
              end
            end
            REQ_REQUEST: begin
              if (!known || !present_r[uix]) begin
                err_nxt = ERR_UNKNOWN;
              end else begin
                waiting_nxt[uix] = 1'b1;
                try_sel          = 1'b1;
              end
            end
            REQ_DONE: begin
              prev_v_nxt  = hold_v_r;
              prev_ix_nxt = hold_v_r ? hold_ix_r : '0;
              hold_v_nxt  = 1'b0;
              hold_ix_nxt = '0;
              try_sel     = 1'b1;
            end
            REQ_LEAVE: begin
              if (known && present_r[uix]) begin
                if (hold_v_r && hold_ix_r == uix) begin
                  hold_v_nxt  = 1'b0;
                  hold_ix_nxt = '0;
                end
                present_nxt[uix] = 1'b0;
                waiting_nxt[uix] = 1'b0;
                prio_we          = 1'b1;
                prio_wd          = '0;
              end
            end
            REQ_TICK: begin
              ticks_nxt = ticks_inc;
              if (pend_r && ticks_inc >= frame_gap_r) begin
                pend_nxt = 1'b0;
                try_sel  = 1'b1;
              end
            end
            default: begin
            end
          endcase

          if (try_sel && !hold_v_nxt) begin
            if (ticks_nxt < frame_gap_r) begin
              pend_nxt = 1'b1;
            end else begin
              pend_nxt  = 1'b0;
              ticks_nxt = '0;
              go_scan   = 1'b1;
            end
          end

          if (go_scan) begin
            state_nxt     = ST_SCAN;
            idx_nxt       = '0;
            cnt_nxt       = '0;
            best_v_nxt    = 1'b0;
            best_ix_nxt   = '0;
            best_prio_nxt = '0;
            prev_cand_nxt = 1'b0;
          end else begin
            strobe_nxt           = 1'b1;
            word_nxt.grant_valid = 1'b0;
            word_nxt.grant_user  = '0;
            word_nxt.busy_res    = hold_v_nxt;
            word_nxt.busy_user   = USER_W'(hold_ix_nxt);
            word_nxt.error       = err_nxt;
          end
        end
      end

      ST_SCAN: begin
        cand    = present_r[idx_r] && waiting_r[idx_r];
        is_prev = prev_v_r && (prev_ix_r == idx_r);
        if (cand) begin
          cnt_now = (cnt_r == 2'd2) ? cnt_r : cnt_r + 1'b1;
          if (is_prev) begin
            pc_now = 1'b1;
          end else if (!best_v_r || prio_r[idx_r] > best_prio_r) begin
            bv_now  = 1'b1;
            bix_now = idx_r;
            bp_now  = prio_r[idx_r];
          end
        end
        cnt_nxt       = cnt_now;
        prev_cand_nxt = pc_now;
        best_v_nxt    = bv_now;
        best_ix_nxt   = bix_now;
        best_prio_nxt = bp_now;
        idx_nxt       = idx_r + 1'b1;

        if (idx_r == IDX_W'(NUM_USERS - 1)) begin
          // lone waiter may be the previous holder
          if (cnt_now == 2'd1 && pc_now) begin
            pick_v  = 1'b1;
            pick_ix = prev_ix_r;
          end else if (bv_now) begin
            pick_v  = 1'b1;
            pick_ix = bix_now;
          end
          if (pick_v) begin
            waiting_nxt[pick_ix] = 1'b0;
            hold_v_nxt           = 1'b1;
            hold_ix_nxt          = pick_ix;
          end
          state_nxt            = ST_IDLE;
          strobe_nxt           = 1'b1;
          word_nxt.grant_valid = pick_v;
          word_nxt.grant_user  = pick_v ? USER_W'(pick_ix) : '0;
          word_nxt.busy_res    = hold_v_nxt;
          word_nxt.busy_user   = USER_W'(hold_ix_nxt);
          word_nxt.error       = err_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      frame_gap_r <= '0;
      present_r   <= '0;
      waiting_r   <= '0;
      hold_v_r    <= 1'b0;
      hold_ix_r   <= '0;
      prev_v_r    <= 1'b0;
      prev_ix_r   <= '0;
      ticks_r     <= '0;
      pend_r      <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      waiting_r <= waiting_nxt;
      hold_v_r  <= hold_v_nxt;
      hold_ix_r <= hold_ix_nxt;
      prev_v_r  <= prev_v_nxt;
      prev_ix_r <= prev_ix_nxt;
      ticks_r   <= ticks_nxt;
      pend_r    <= pend_nxt;
      strobe_r  <= strobe_nxt;
      if (cfg_we && paddr[2] == REG_FRAME_GAP) begin
        frame_gap_r <= pwdata[GAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    best_v_r    <= best_v_nxt;
    best_ix_r   <= best_ix_nxt;
    best_prio_r <= best_prio_nxt;
    prev_cand_r <= prev_cand_nxt;
    err_r       <= err_nxt;
    word_r      <= word_nxt;
    if (prio_we) begin
      prio_r[prio_wa] <= prio_wd;
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = word_r;

  a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.grant_valid |->
      out_word.busy_res && out_word.busy_user == out_word.grant_user)
    else $error("grant without matching holder");

  a_grant_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.grant_valid |-> out_word.error == ERR_NONE)
    else $error("grant flagged with error");

  a_scan_ends_out: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("pass ended without result");

  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_strobe || busy)
    else $error("word taken without result or pass");

endmodule

`default_nettype wire
